// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL of the jitter buffer.
// Included by the top level; holds no logic of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// The property must hold on every rising clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// The expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

// ===== rtl/core/bfsf_pkg.sv =====
// Shared types and constants of the byte jitter buffer.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package bfsf_pkg;

  // Field widths of the stream beats.
  localparam int KIND_W = 2;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;
  localparam int FILL_W = 13;
  localparam int CNT_W  = 32;

  // Packed bus widths.
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 88;
  localparam int OUT_TUSER_W = 2;

  // Item kinds on the input stream.
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             write;
    logic             flush;
    logic             read_start;
    logic [LEN_W-1:0] read_len;
    logic             fetch;
    logic             emit;
    logic             emit_last;
  } bfsf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } bfsf_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/bfsf_ctrl.sv =====
// Controller of the byte jitter buffer: accepts items and sequences read bursts.
// Depends on bfsf_pkg; drives the datapath through bfsf_cmd_t.
`default_nettype none

module bfsf_ctrl #(
  parameter int MAX_READ = 64
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  input  wire  [bfsf_pkg::KIND_W-1:0]         kind,
  input  wire  [bfsf_pkg::LEN_W-1:0]          read_length,
  output logic                                in_ready,
  input  bfsf_pkg::bfsf_status_t              status,
  output bfsf_pkg::bfsf_cmd_t                 cmd
);
  import bfsf_pkg::*;

  localparam int RW = $clog2(MAX_READ + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t           state, state_next;
  logic [RW-1:0]    remaining, remaining_next;
  logic [LEN_W-1:0] len_sat;
  logic             accept;
  logic             is_last;

  // Requests beyond the burst limit are cut to the limit.
  assign len_sat  = (read_length > LEN_W'(MAX_READ)) ? LEN_W'(MAX_READ) : read_length;
  assign in_ready = (state == ST_IDLE) && status.out_free;
  assign accept   = in_valid && in_ready;
  assign is_last  = (remaining == RW'(1));

  // Next state and command decode.
  always_comb begin
    state_next     = state;
    remaining_next = remaining;
    cmd            = '0;
    cmd.read_len   = len_sat;
    cmd.emit_last  = is_last;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_WRITE: cmd.write = 1'b1;
            KIND_FLUSH: cmd.flush = 1'b1;
            KIND_READ: begin
              if (len_sat != '0) begin
                cmd.read_start = 1'b1;
                cmd.fetch      = 1'b1;
                remaining_next = RW'(len_sat);
                state_next     = ST_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit       = 1'b1;
          remaining_next = remaining - RW'(1);
          if (is_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.fetch = 1'b1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      remaining <= '0;
    end else begin
      state     <= state_next;
      remaining <= remaining_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bfsf_datapath.sv =====
// Datapath of the byte jitter buffer: byte store, ring indices, counters, output register.
// Depends on bfsf_pkg; follows the commands of bfsf_ctrl.
`default_nettype none

module bfsf_datapath #(
  parameter int DEPTH = 4096
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_wr_en,
  input  wire  [bfsf_pkg::FILL_W-1:0]        cfg_wr_data,
  input  wire  [bfsf_pkg::BYTE_W-1:0]        data_byte,
  input  wire                                last_of_write,
  input  bfsf_pkg::bfsf_cmd_t                cmd,
  output bfsf_pkg::bfsf_status_t             status,
  input  wire                                out_ready,
  output logic                               out_valid,
  output logic [bfsf_pkg::BYTE_W-1:0]        out_byte,
  output logic                               out_from_buffer,
  output logic                               out_last,
  output logic                               out_write_accepted,
  output logic [bfsf_pkg::FILL_W-1:0]        out_fill_level,
  output logic [bfsf_pkg::CNT_W-1:0]         out_overrun_total,
  output logic [bfsf_pkg::CNT_W-1:0]         out_underrun_total
);
  import bfsf_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CAPW = $clog2(DEPTH + 1);
  localparam int CMPW = (CAPW > FILL_W) ? CAPW : FILL_W;

  logic [BYTE_W-1:0] mem [DEPTH];

  logic [AW-1:0]     write_index, write_index_next;
  logic [AW-1:0]     read_index, read_index_next;
  logic [CAPW-1:0]   fill, fill_next;
  logic [CAPW-1:0]   capacity, capacity_next;
  logic [CNT_W-1:0]  overrun, overrun_next;
  logic [CNT_W-1:0]  underrun, underrun_next;
  logic              burst_dropped, burst_dropped_next;
  logic [BYTE_W-1:0] rdata;
  logic              rd_from_buf;
  logic              has_room;
  logic              has_data;
  logic              do_store;
  logic              do_pop;
  logic              out_load;
  logic [CMPW-1:0]   cfg_val;

  assign has_room = (fill < capacity);
  assign has_data = (fill != '0);
  assign do_store = cmd.write && has_room;
  assign do_pop   = cmd.fetch && has_data;
  assign out_load = cmd.write || cmd.flush || cmd.emit;

  assign status.out_free = !out_valid || out_ready;

  // Ring index advance, wrapping at the configured capacity.
  always_comb begin
    if ((CMPW'(write_index) + CMPW'(1)) >= CMPW'(capacity)) begin
      write_index_next = '0;
    end else begin
      write_index_next = write_index + AW'(1);
    end
    if ((CMPW'(read_index) + CMPW'(1)) >= CMPW'(capacity)) begin
      read_index_next = '0;
    end else begin
      read_index_next = read_index + AW'(1);
    end
  end

  // Capacity clamp: zero reads as one, anything above the store depth as the depth.
  assign cfg_val = CMPW'(cfg_wr_data);
  always_comb begin
    if (cfg_val == '0) begin
      capacity_next = CAPW'(1);
    end else if (cfg_val > CMPW'(DEPTH)) begin
      capacity_next = CAPW'(DEPTH);
    end else begin
      capacity_next = CAPW'(cfg_val);
    end
  end

  // Fill level and burst accounting.
  always_comb begin
    fill_next          = fill;
    overrun_next       = overrun;
    underrun_next      = underrun;
    burst_dropped_next = burst_dropped;
    if (cfg_wr_en || cmd.flush) begin
      fill_next = '0;
    end else if (do_store) begin
      fill_next = fill + CAPW'(1);
    end else if (do_pop) begin
      fill_next = fill - CAPW'(1);
    end
    if (cmd.write) begin
      if (!has_room && !burst_dropped) begin
        overrun_next       = overrun + CNT_W'(1);
        burst_dropped_next = 1'b1;
      end
      if (last_of_write) begin
        burst_dropped_next = 1'b0;
      end
    end
    if (cmd.read_start && (CMPW'(fill) < CMPW'(cmd.read_len))) begin
      underrun_next = underrun + CNT_W'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index   <= '0;
      read_index    <= '0;
      fill          <= '0;
      capacity      <= CAPW'(DEPTH);
      overrun       <= '0;
      underrun      <= '0;
      burst_dropped <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      fill          <= fill_next;
      overrun       <= overrun_next;
      underrun      <= underrun_next;
      burst_dropped <= burst_dropped_next;
      if (cfg_wr_en) begin
        capacity <= capacity_next;
      end
      if (cfg_wr_en || cmd.flush) begin
        write_index <= '0;
        read_index  <= '0;
      end else begin
        if (do_store) begin
          write_index <= write_index_next;
        end
        if (do_pop) begin
          read_index <= read_index_next;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Byte store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (do_store) begin
      mem[write_index] <= data_byte;
    end
    if (cmd.fetch) begin
      rdata       <= mem[read_index];
      rd_from_buf <= has_data;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (cmd.emit) begin
        out_byte           <= rd_from_buf ? rdata : '0;
        out_from_buffer    <= rd_from_buf;
        out_last           <= cmd.emit_last;
        out_write_accepted <= 1'b0;
        out_fill_level     <= FILL_W'(fill);
        out_overrun_total  <= overrun;
        out_underrun_total <= underrun;
      end else begin
        out_byte           <= '0;
        out_from_buffer    <= 1'b0;
        out_last           <= 1'b1;
        out_write_accepted <= do_store;
        out_fill_level     <= FILL_W'(fill_next);
        out_overrun_total  <= overrun_next;
        out_underrun_total <= underrun;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/byte_fifo_silence_fill.sv =====
// Top level of the byte jitter buffer with silence fill on underrun.
// Depends on bfsf_pkg, bfsf_ctrl, bfsf_datapath and assert_macros.svh.
//
//  Channel  | Direction | Beat contents
//  s_axis   | in        | tuser kind, tlast last_of_write, tdata data_byte and read_length
//  m_axis   | out       | tuser flags, tlast last result of item, tdata byte, fill, counters
//  cfg      | in        | capacity write, no handshake
//
// A write or flush item yields one beat; writes stream at one per cycle while the output is free.
// A read of N bytes, cut to MAX_READ, starts with a registered read of the byte store,
// then sends one beat per cycle while the output is free, the next byte fetched behind it.
// Reset is synchronous; it empties the buffer, clears both counters and sets the capacity
// to DEPTH. The store itself is not cleared. A stalled output beat holds the input off.
`default_nettype none
`include "assert_macros.svh"

module byte_fifo_silence_fill #(
  parameter int DEPTH    = 4096,
  parameter int MAX_READ = 64
) (
  input  wire                                   clk,
  input  wire                                   rst,
  // Configuration: capacity.
  input  wire                                   cfg_wr_en,
  input  wire  [bfsf_pkg::FILL_W-1:0]           cfg_wr_data,
  // Input stream.
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire  [bfsf_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // data_byte[7:0], read_length[14:8]
  input  wire  [bfsf_pkg::KIND_W-1:0]           s_axis_tuser,  // kind[1:0]
  input  wire                                   s_axis_tlast,
  // Output stream.
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  output logic [bfsf_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,  // out_byte[7:0], fill_level[20:8],
                                                               // overrun_total[52:21],
                                                               // underrun_total[84:53]
  output logic [bfsf_pkg::OUT_TUSER_W-1:0]      m_axis_tuser,  // from_buffer[0], write_accepted[1]
  output logic                                  m_axis_tlast
);
  import bfsf_pkg::*;

  bfsf_cmd_t         cmd;
  bfsf_status_t      status;
  logic [BYTE_W-1:0] out_byte;
  logic              out_from_buffer;
  logic              out_write_accepted;
  logic [FILL_W-1:0] out_fill_level;
  logic [CNT_W-1:0]  out_overrun_total;
  logic [CNT_W-1:0]  out_underrun_total;

  bfsf_ctrl #(
    .MAX_READ (MAX_READ)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .kind        (s_axis_tuser),
    .read_length (s_axis_tdata[14:8]),
    .in_ready    (s_axis_tready),
    .status      (status),
    .cmd         (cmd)
  );

  bfsf_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .data_byte          (s_axis_tdata[7:0]),
    .last_of_write      (s_axis_tlast),
    .cmd                (cmd),
    .status             (status),
    .out_ready          (m_axis_tready),
    .out_valid          (m_axis_tvalid),
    .out_byte           (out_byte),
    .out_from_buffer    (out_from_buffer),
    .out_last           (m_axis_tlast),
    .out_write_accepted (out_write_accepted),
    .out_fill_level     (out_fill_level),
    .out_overrun_total  (out_overrun_total),
    .out_underrun_total (out_underrun_total)
  );

  // Pack the result beat.
  assign m_axis_tdata = {3'b000, out_underrun_total, out_overrun_total, out_fill_level, out_byte};
  assign m_axis_tuser = {out_write_accepted, out_from_buffer};

  // An item is never taken while a finished beat is stuck at the output.
  `ASSERT_NEVER(a_no_accept_on_stall, clk, rst,
    s_axis_tvalid && s_axis_tready && m_axis_tvalid && !m_axis_tready,
    "input beat accepted while output beat stalled")

  // A taken write item yields its single result on the next cycle.
  `ASSERT_HOLDS(a_write_result, clk, rst,
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_WRITE) |=>
      m_axis_tvalid && m_axis_tlast,
    "write item did not produce a last beat")

  // Inside a read burst, the next beat follows right after a non-final one is taken.
  `ASSERT_HOLDS(a_burst_continues, clk, rst,
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid,
    "read burst stalled between beats")

  // The input stays closed for the whole read burst.
  `ASSERT_NEVER(a_closed_in_burst, clk, rst,
    m_axis_tvalid && !m_axis_tlast && s_axis_tready,
    "input opened in the middle of a read burst")

endmodule

`default_nettype wire

// ===== tb/bfsf_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the byte jitter buffer: watches the capacity, input and output channels,
// predicts every output beat and compares it field by field with what the block sends.
// Depends on bfsf_pkg for field widths and item kinds.
module bfsf_checker #(
  parameter int DEPTH    = 4096,
  parameter int MAX_READ = 64
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_wr_en,
  input  wire  [bfsf_pkg::FILL_W-1:0]        cfg_wr_data,
  input  wire                                s_axis_tvalid,
  input  wire                                s_axis_tready,
  input  wire  [bfsf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // data_byte, read_length
  input  wire  [bfsf_pkg::KIND_W-1:0]        s_axis_tuser,  // kind
  input  wire                                s_axis_tlast,
  input  wire                                m_axis_tvalid,
  input  wire                                m_axis_tready,
  input  wire  [bfsf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // out_byte, fill_level,
                                                            // overrun_total, underrun_total
  input  wire  [bfsf_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,  // from_buffer, write_accepted
  input  wire                                m_axis_tlast,
  output int                                 fail_count,
  output int                                 beats_due
);
  import bfsf_pkg::*;

  localparam int MAX_PRINTED = 40;

  // One output beat as the block should send it.
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              from_buffer;
    logic              last;
    logic              write_accepted;
    logic [FILL_W-1:0] fill_level;
    logic [CNT_W-1:0]  overrun_total;
    logic [CNT_W-1:0]  underrun_total;
  } beat_t;

  // Expected beats, oldest first.
  beat_t due_q[$];

  // Predicted state of the jitter buffer.
  logic [BYTE_W-1:0] ring [DEPTH];
  int unsigned       head;
  int unsigned       tail;
  int unsigned       held;
  int unsigned       cap;
  logic [CNT_W-1:0]  overruns;
  logic [CNT_W-1:0]  underruns;
  logic              burst_lost;
  int unsigned       beat_no;

  initial begin
    fail_count = 0;
    beats_due  = 0;
  end

  task automatic report_mismatch(input string what);
    if (fail_count < MAX_PRINTED) begin
      $display("%0t ns checker: %s", $time, what);
    end
    fail_count++;
  endtask

  function automatic int unsigned step_ptr(input int unsigned ptr);
    return (ptr + 1 >= cap) ? 0 : ptr + 1;
  endfunction

  function automatic void empty_ring();
    head = 0;
    tail = 0;
    held = 0;
  endfunction

  // A capacity write clamps to 1..DEPTH and empties the buffer.
  function automatic void set_cap(input logic [FILL_W-1:0] value);
    if (value == 0) begin
      cap = 1;
    end else if (value > DEPTH) begin
      cap = DEPTH;
    end else begin
      cap = 32'(value);
    end
    empty_ring();
  endfunction

  // Queue a beat carrying the current fill level and counters.
  function automatic void queue_beat(input logic [BYTE_W-1:0] b, input logic fb,
                                     input logic lst, input logic acc);
    beat_t r;
    r.out_byte       = b;
    r.from_buffer    = fb;
    r.last           = lst;
    r.write_accepted = acc;
    r.fill_level     = FILL_W'(held);
    r.overrun_total  = overruns;
    r.underrun_total = underruns;
    due_q.push_back(r);
  endfunction

  // Work out the beats that one input item causes.
  function automatic void predict_item(input logic [KIND_W-1:0] kind,
                                       input logic [BYTE_W-1:0] data,
                                       input logic lastw, input logic [LEN_W-1:0] len);
    int unsigned       n;
    logic              acc;
    logic [BYTE_W-1:0] b;
    case (kind)
      KIND_WRITE: begin
        acc = 1'b0;
        if (held < cap) begin
          ring[tail] = data;
          tail = step_ptr(tail);
          held++;
          acc = 1'b1;
        end else if (!burst_lost) begin
          // Only the first drop of a burst counts as an overrun.
          overruns++;
          burst_lost = 1'b1;
        end
        if (lastw) begin
          burst_lost = 1'b0;
        end
        queue_beat('0, 1'b0, 1'b1, acc);
      end
      KIND_READ: begin
        if (len != 0) begin
          n = (len > MAX_READ) ? MAX_READ : len;
          if (held < n) begin
            underruns++;
          end
          // Stored bytes first, then silence.
          for (int k = 0; k < int'(n); k++) begin
            if (held > 0) begin
              b = ring[head];
              head = step_ptr(head);
              held--;
              queue_beat(b, 1'b1, k == int'(n) - 1, 1'b0);
            end else begin
              queue_beat('0, 1'b0, k == int'(n) - 1, 1'b0);
            end
          end
        end
      end
      KIND_FLUSH: begin
        empty_ring();
        queue_beat('0, 1'b0, 1'b1, 1'b0);
      end
      default: begin
      end
    endcase
  endfunction

  task automatic check_field(input string name, input logic [CNT_W-1:0] got,
                             input logic [CNT_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("beat %0d: %s is 0x%0h, expected 0x%0h", beat_no, name,
                                got, want));
    end
  endtask

  // Compare an accepted output beat with the oldest expectation.
  task automatic check_beat();
    beat_t want;
    if (due_q.size() == 0) begin
      report_mismatch($sformatf("beat %0d arrived with nothing expected", beat_no));
    end else begin
      want = due_q.pop_front();
      check_field("out_byte", CNT_W'(m_axis_tdata[0 +: BYTE_W]), CNT_W'(want.out_byte));
      check_field("from_buffer", CNT_W'(m_axis_tuser[0]), CNT_W'(want.from_buffer));
      check_field("last", CNT_W'(m_axis_tlast), CNT_W'(want.last));
      check_field("write_accepted", CNT_W'(m_axis_tuser[1]), CNT_W'(want.write_accepted));
      check_field("fill_level", CNT_W'(m_axis_tdata[BYTE_W +: FILL_W]),
                  CNT_W'(want.fill_level));
      check_field("overrun_total", m_axis_tdata[BYTE_W + FILL_W +: CNT_W],
                  want.overrun_total);
      check_field("underrun_total", m_axis_tdata[BYTE_W + FILL_W + CNT_W +: CNT_W],
                  want.underrun_total);
    end
    beat_no++;
  endtask

  // Watch all channels at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      due_q.delete();
      empty_ring();
      cap        = DEPTH;
      overruns   = '0;
      underruns  = '0;
      burst_lost = 1'b0;
      beat_no    = 0;
    end else begin
      if (cfg_wr_en) begin
        set_cap(cfg_wr_data);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_item(s_axis_tuser, s_axis_tdata[0 +: BYTE_W], s_axis_tlast,
                     s_axis_tdata[BYTE_W +: LEN_W]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_beat();
      end
    end
    beats_due = due_q.size();
  end

endmodule

// ===== tb/byte_fifo_silence_fill_test.sv =====
`timescale 1ns / 100ps
// Top of the jitter buffer testbench: clock, reset, capacity writes, input beats and
// output back-pressure, plus the verdict. Depends on bfsf_pkg, the block and bfsf_checker.
module byte_fifo_silence_fill_test;
  import bfsf_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int RUN_LIMIT    = 1000000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 60;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_wr_en = 1'b0;
  logic [FILL_W-1:0]       cfg_wr_data = '0;
  logic                    s_axis_tvalid = 1'b0;
  wire                     s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
  logic [KIND_W-1:0]       s_axis_tuser = '0;
  logic                    s_axis_tlast = 1'b0;
  wire                     m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  wire  [OUT_TDATA_W-1:0]  m_axis_tdata;
  wire  [OUT_TUSER_W-1:0]  m_axis_tuser;
  wire                     m_axis_tlast;

  int   fail_count;
  int   beats_due;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  int   cycles = 0;
  logic hold_active = 1'b0;
  event rx_hold_ev;
  int   phase_caps [PHASES] = '{2, 8191, 1, 4096, 5, 0};

  byte_fifo_silence_fill i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  bfsf_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (fail_count),
    .beats_due     (beats_due)
  );

  // Free-running clock.
  initial begin
    forever #10 clk = ~clk;
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Output back-pressure: random stalls, or a long hold when one is requested.
  always @(negedge clk) begin
    m_axis_tready <= !hold_active && ($urandom_range(99) >= rx_idle_pct);
  end

  // The long hold is timed here, apart from the sender.
  initial begin
    forever begin
      @(rx_hold_ev);
      @(posedge clk);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active = 1'b0;
    end
  end

  // Offer one beat, with random gaps before it, and wait until it is taken.
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] data,
                           input logic lastw, input logic [LEN_W-1:0] len);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tlast  <= lastw;
    s_axis_tdata  <= {1'b0, len, data};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering and wait until every expected beat has come out.
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (beats_due != 0) @(negedge clk);
  endtask

  // Capacity is only written once the block is idle; an ignored item may still be
  // in flight, so let it settle before the write.
  task automatic set_capacity(input logic [FILL_W-1:0] value);
    quiesce();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Idle rates change just after a rising edge, away from the receiver's updates.
  task automatic set_idling(input int tx_pct, input int rx_pct);
    @(posedge clk);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    @(negedge clk);
  endtask

  // Mostly framed write bursts and sensible reads; some flushes, unused kinds, broken framing and odd lengths.
  task automatic random_items(input int count);
    int   sent;
    int   pick;
    int   burst_len;
    int   len;
    logic lastw;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        burst_len = $urandom_range(1, 6);
        for (int i = 0; i < burst_len; i++) begin
          lastw = (i == burst_len - 1);
          if ($urandom_range(9) == 0) begin
            lastw = 1'($urandom_range(1));
          end
          send_item(KIND_WRITE, BYTE_W'($urandom_range(255)), lastw,
                    LEN_W'($urandom_range(127)));
        end
        sent += burst_len;
      end else if (pick < 85) begin
        pick = $urandom_range(99);
        if (pick < 80) begin
          len = $urandom_range(1, 8);
        end else if (pick < 90) begin
          len = $urandom_range(9, 64);
        end else if (pick < 95) begin
          len = 0;
        end else begin
          len = $urandom_range(65, 127);
        end
        send_item(KIND_READ, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                  LEN_W'(len));
        if (len != 0) begin
          sent++;
        end
      end else if (pick < 93) begin
        send_item(KIND_FLUSH, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                  LEN_W'($urandom_range(127)));
        sent++;
      end else begin
        send_item(KIND_UNUSED, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                  LEN_W'($urandom_range(127)));
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Full capacity: stored bytes, padding, zero and oversized reads, flush, unused kind.
    send_item(KIND_WRITE, 8'h00, 1'b0, 7'd0);
    send_item(KIND_WRITE, 8'hFF, 1'b0, 7'h7F);
    send_item(KIND_WRITE, 8'hA5, 1'b1, 7'd0);
    send_item(KIND_READ, 8'h00, 1'b0, 7'd2);
    send_item(KIND_READ, 8'hFF, 1'b1, 7'd3);
    send_item(KIND_READ, 8'h00, 1'b0, 7'd0);
    send_item(KIND_UNUSED, 8'hFF, 1'b1, 7'h7F);
    send_item(KIND_WRITE, 8'h5A, 1'b1, 7'd0);
    send_item(KIND_FLUSH, 8'h00, 1'b0, 7'd0);
    send_item(KIND_READ, 8'h00, 1'b0, 7'd1);
    send_item(KIND_READ, 8'h00, 1'b0, 7'h7F);
    send_item(KIND_READ, 8'h00, 1'b0, 7'd64);

    // Capacity zero acts as one: drops within a burst count once, a new burst again.
    set_capacity('0);
    send_item(KIND_WRITE, 8'h11, 1'b0, 7'd0);
    send_item(KIND_WRITE, 8'h22, 1'b0, 7'd0);
    send_item(KIND_WRITE, 8'h33, 1'b1, 7'd0);
    send_item(KIND_WRITE, 8'h44, 1'b1, 7'd0);
    send_item(KIND_READ, 8'h00, 1'b0, 7'd2);
    send_item(KIND_WRITE, 8'h66, 1'b1, 7'd0);

    // A capacity write empties the buffer; then the indices wrap at capacity three.
    set_capacity(13'd3);
    send_item(KIND_READ, 8'h00, 1'b0, 7'd1);
    send_item(KIND_WRITE, 8'h01, 1'b0, 7'd0);
    send_item(KIND_WRITE, 8'h02, 1'b0, 7'd0);
    send_item(KIND_WRITE, 8'h03, 1'b0, 7'd0);
    send_item(KIND_WRITE, 8'h04, 1'b1, 7'd0);
    send_item(KIND_READ, 8'h00, 1'b0, 7'd2);
    send_item(KIND_WRITE, 8'h05, 1'b0, 7'd0);
    send_item(KIND_WRITE, 8'h06, 1'b1, 7'd0);
    send_item(KIND_READ, 8'h00, 1'b0, 7'd4);

    // Random phases over several capacities and idle patterns.
    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) begin
        set_capacity(FILL_W'($urandom_range(3, 64)));
      end else begin
        set_capacity(FILL_W'(phase_caps[p]));
      end
      if (p < 2) begin
        set_idling(12, 65);
      end else if (p < 4) begin
        set_idling(65, 12);
      end else begin
        set_idling(0, 0);
      end
      // Hold the output long enough for the block to back up onto its input.
      if (p == 4) begin
        -> rx_hold_ev;
      end
      random_items(PHASE_ITEMS / 2);
      quiesce();
      random_items(PHASE_ITEMS - PHASE_ITEMS / 2);
    end

    quiesce();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && beats_due == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
